/* rtl/adaa_pkg.sv */
package adaa_pkg;

	// Field widths.
	localparam int InW   = 16;
	localparam int OutW  = 14;
	localparam int ThrW  = 12;
	localparam logic [ThrW-1:0] ThrReset = ThrW'(4);

	// Antiderivative table, unsigned Q8.16.
	localparam int TableSize = 256;
	localparam int TableLast = TableSize - 1;
	localparam int IdxW      = $clog2(TableSize);
	localparam int RomW      = 24;

	// Fixed-point constants in Q3.12 and Q8.16.
	localparam int HalfRange   = 12288;
	localparam int FullRange   = 24576;
	localparam int RndShift    = 13;
	localparam int OutsideBase = 196608;
	localparam int MidWide     = 24576;
	localparam int OneOut      = 4096;

	// Datapath widths.
	localparam int PW    = 15;
	localparam int TW    = PW + IdxW;
	localparam int AccW  = RomW + PW + 1;
	localparam int NumW  = 47;
	localparam int DenW  = 46;
	localparam int QW    = 13;
	localparam int KW    = 4;
	localparam logic [31:0] MidC = 32'd27 << 26;

	localparam logic [63:0] TableLastSq    = 64'(TableLast) * 64'(TableLast);
	localparam logic [63:0] TwoTableLastSq = 64'd2 * TableLastSq;
	localparam logic [63:0] Ln2Q30         = 64'd744261118;

	typedef logic [RomW-1:0] rom_t [TableSize];

	// One table point at x = 3n/d: n^2/(2d^2) + (4/3) ln(1 + 3n^2/d^2).
	function automatic logic [RomW-1:0] rom_point(longint n);
		logic [63:0] n2;
		logic [63:0] a;
		logic [63:0] k;
		logic [63:0] frac;
		logic [63:0] lg;
		logic [63:0] ln;
		logic [63:0] t1;
		logic [63:0] t2;
		n2 = 64'(n * n);
		a = ((TableLastSq + 64'd3 * n2) << 30) / TableLastSq;
		k = '0;
		frac = '0;
		for (int j = 0; j < 4; j++) begin
			if (a >= 64'h8000_0000) begin
				a = a >> 1;
				k = k + 64'd1;
			end
		end
		for (int b = 29; b >= 0; b--) begin
			a = (a * a) >> 30;
			if (a >= 64'h8000_0000) begin
				a = a >> 1;
				frac = frac | (64'd1 << b);
			end
		end
		lg = (k << 30) + frac;
		ln = (lg * Ln2Q30 + (64'd1 << 29)) >> 30;
		t1 = ((n2 << 16) + TableLastSq) / TwoTableLastSq;
		t2 = (ln * 64'd4 + 64'd24576) / 64'd49152;
		return RomW'(t1 + t2);
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < TableSize; i++) begin
			r[i] = rom_point(longint'(2 * i - TableLast));
		end
		return r;
	endfunction

	localparam rom_t Rom = build_rom();

	// Exact floor(u / 3) for any 32-bit u.
	function automatic logic [31:0] div3(logic [31:0] u);
		logic [63:0] p;
		p = {32'b0, u} * 64'hAAAA_AAAB;
		return 32'(p >> 33);
	endfunction

	// Datapath operations, one per microcode step.
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_FX,
		OP_IDX,
		OP_ROM,
		OP_MUL,
		OP_MAC,
		OP_RND,
		OP_DIV3,
		OP_QUO,
		OP_MSQ,
		OP_MCS,
		OP_MMUL,
		OP_MLD,
		OP_CHK,
		OP_ITER,
		OP_DONE
	} op_t;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_IN,
		HOLD_OUT
	} hold_t;

	typedef enum logic [2:0] {
		JMP_NEVER,
		JMP_ALWAYS,
		JMP_OUTSIDE,
		JMP_MID,
		JMP_WIDE,
		JMP_SAT,
		JMP_MORE
	} jmp_t;

	localparam int NumSteps = 17;
	localparam int StepW    = $clog2(NumSteps);

	localparam logic [StepW-1:0] StIdle = StepW'(0);
	localparam logic [StepW-1:0] StFx   = StepW'(1);
	localparam logic [StepW-1:0] StIdx  = StepW'(2);
	localparam logic [StepW-1:0] StRom  = StepW'(3);
	localparam logic [StepW-1:0] StMul  = StepW'(4);
	localparam logic [StepW-1:0] StMac  = StepW'(5);
	localparam logic [StepW-1:0] StRnd  = StepW'(6);
	localparam logic [StepW-1:0] StDiv3 = StepW'(7);
	localparam logic [StepW-1:0] StSel  = StepW'(8);
	localparam logic [StepW-1:0] StQuo  = StepW'(9);
	localparam logic [StepW-1:0] StMsq  = StepW'(10);
	localparam logic [StepW-1:0] StMcs  = StepW'(11);
	localparam logic [StepW-1:0] StMmul = StepW'(12);
	localparam logic [StepW-1:0] StMld  = StepW'(13);
	localparam logic [StepW-1:0] StChk  = StepW'(14);
	localparam logic [StepW-1:0] StIter = StepW'(15);
	localparam logic [StepW-1:0] StDone = StepW'(16);

	typedef struct packed {
		op_t              op;
		hold_t            hold;
		jmp_t             jmp;
		logic [StepW-1:0] target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic en;
	} dp_ctrl_t;

	typedef struct packed {
		logic outside;
		logic mid;
		logic wide;
		logic sat;
		logic more;
	} dp_stat_t;

	// The microprogram.
	function automatic uword_t ucode_word(logic [StepW-1:0] pc);
		uword_t w;
		unique case (pc)
			StIdle: w = '{op: OP_LOAD, hold: HOLD_IN,   jmp: JMP_NEVER,   target: StIdle};
			StFx:   w = '{op: OP_FX,   hold: HOLD_NONE, jmp: JMP_OUTSIDE, target: StSel};
			StIdx:  w = '{op: OP_IDX,  hold: HOLD_NONE, jmp: JMP_NEVER,   target: StIdle};
			StRom:  w = '{op: OP_ROM,  hold: HOLD_NONE, jmp: JMP_NEVER,   target: StIdle};
			StMul:  w = '{op: OP_MUL,  hold: HOLD_NONE, jmp: JMP_NEVER,   target: StIdle};
			StMac:  w = '{op: OP_MAC,  hold: HOLD_NONE, jmp: JMP_NEVER,   target: StIdle};
			StRnd:  w = '{op: OP_RND,  hold: HOLD_NONE, jmp: JMP_NEVER,   target: StIdle};
			StDiv3: w = '{op: OP_DIV3, hold: HOLD_NONE, jmp: JMP_NEVER,   target: StIdle};
			StSel:  w = '{op: OP_NOP,  hold: HOLD_NONE, jmp: JMP_MID,     target: StMsq};
			StQuo:  w = '{op: OP_QUO,  hold: HOLD_NONE, jmp: JMP_ALWAYS,  target: StChk};
			StMsq:  w = '{op: OP_MSQ,  hold: HOLD_NONE, jmp: JMP_WIDE,    target: StDone};
			StMcs:  w = '{op: OP_MCS,  hold: HOLD_NONE, jmp: JMP_NEVER,   target: StIdle};
			StMmul: w = '{op: OP_MMUL, hold: HOLD_NONE, jmp: JMP_NEVER,   target: StIdle};
			StMld:  w = '{op: OP_MLD,  hold: HOLD_NONE, jmp: JMP_NEVER,   target: StIdle};
			StChk:  w = '{op: OP_CHK,  hold: HOLD_NONE, jmp: JMP_SAT,     target: StDone};
			StIter: w = '{op: OP_ITER, hold: HOLD_NONE, jmp: JMP_MORE,    target: StIter};
			StDone: w = '{op: OP_DONE, hold: HOLD_OUT,  jmp: JMP_ALWAYS,  target: StIdle};
			default: w = '{op: OP_NOP, hold: HOLD_NONE, jmp: JMP_ALWAYS,  target: StIdle};
		endcase
		return w;
	endfunction

endpackage

/* rtl/adaa_in_if.sv */
interface adaa_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [adaa_pkg::InW-1:0]     sample_in;

	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

/* rtl/adaa_out_if.sv */
interface adaa_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [adaa_pkg::OutW-1:0]    sample_out;

	modport source(output valid, output sample_out, input ready);
	modport sink(input valid, input sample_out, output ready);
endinterface

/* rtl/adaa_seq.sv */
module adaa_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  adaa_pkg::dp_stat_t stat,
	input  logic               in_valid,
	input  logic               out_busy,
	output adaa_pkg::dp_ctrl_t ctrl
);

	logic [adaa_pkg::StepW-1:0] pc_q;
	logic [adaa_pkg::StepW-1:0] pc_d;
	adaa_pkg::uword_t           word;
	logic                       held;
	logic                       take;

	assign word = adaa_pkg::ucode_word(pc_q);

	always_comb begin
		unique case (word.hold)
			adaa_pkg::HOLD_IN:  held = !in_valid;
			adaa_pkg::HOLD_OUT: held = out_busy;
			default:            held = 1'b0;
		endcase

		unique case (word.jmp)
			adaa_pkg::JMP_ALWAYS:  take = 1'b1;
			adaa_pkg::JMP_OUTSIDE: take = stat.outside;
			adaa_pkg::JMP_MID:     take = stat.mid;
			adaa_pkg::JMP_WIDE:    take = stat.wide;
			adaa_pkg::JMP_SAT:     take = stat.sat;
			adaa_pkg::JMP_MORE:    take = stat.more;
			default:               take = 1'b0;
		endcase

		if (held) begin
			pc_d = pc_q;
		end else if (take) begin
			pc_d = word.target;
		end else begin
			pc_d = pc_q + adaa_pkg::StepW'(1);
		end

		ctrl.op = word.op;
		ctrl.en = !held;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= adaa_pkg::StIdle;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

/* rtl/adaa_dp.sv */
module adaa_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  adaa_pkg::dp_ctrl_t                 ctrl,
	input  logic signed [adaa_pkg::InW-1:0]    sample_in,
	input  logic [adaa_pkg::ThrW-1:0]          thr,
	output adaa_pkg::dp_stat_t                 stat,
	output logic [adaa_pkg::OutW-1:0]          shaped
);

	// Sample history, reset to zero.
	logic [adaa_pkg::InW-1:0]  prev_q;
	logic [adaa_pkg::RomW-1:0] fp_q;

	logic [adaa_pkg::InW-1:0]  x_q;
	logic [adaa_pkg::RomW-1:0] f_q;
	logic [adaa_pkg::TW-1:0]   t_q;
	logic [adaa_pkg::IdxW-1:0] idx_q;
	logic [adaa_pkg::PW-1:0]   r_q;
	logic [adaa_pkg::RomW-1:0] ra_q;
	logic [adaa_pkg::RomW-1:0] rb_q;
	logic [adaa_pkg::AccW-1:0] acc_q;
	logic [29:0]               sq_q;
	logic [31:0]               cs_q;
	logic [32:0]               c9_q;
	logic [adaa_pkg::NumW-1:0] num_q;
	logic [adaa_pkg::DenW-1:0] den_q;
	logic [adaa_pkg::QW-1:0]   q_q;
	logic [adaa_pkg::KW-1:0]   k_q;
	logic                      sat_q;
	logic                      neg_q;

	logic [adaa_pkg::InW:0]       dx;
	logic [adaa_pkg::InW:0]       adx17;
	logic [adaa_pkg::InW-1:0]     adx;
	logic [adaa_pkg::InW:0]       s;
	logic [adaa_pkg::InW:0]       as17;
	logic [adaa_pkg::PW-1:0]      as15;
	logic [adaa_pkg::InW-1:0]     ax;
	logic [adaa_pkg::InW:0]       p17;
	logic [adaa_pkg::IdxW-1:0]    idx_n;
	logic [adaa_pkg::PW-1:0]      wgt;
	logic [adaa_pkg::RomW+adaa_pkg::PW-1:0] prod_a;
	logic [adaa_pkg::RomW+adaa_pkg::PW-1:0] prod_b;
	logic [adaa_pkg::NumW-1:0]    mprod;
	logic [adaa_pkg::RomW:0]      fdiff;
	logic [adaa_pkg::RomW-1:0]    afd;
	logic [adaa_pkg::NumW-1:0]    sat_lim;
	logic                         ge;
	logic [adaa_pkg::QW-1:0]      mag;
	logic [adaa_pkg::OutW-1:0]    mag_ext;

	// Step and sum of the two samples, both 17-bit two's complement.
	assign dx    = {x_q[adaa_pkg::InW-1], x_q} - {prev_q[adaa_pkg::InW-1], prev_q};
	assign adx17 = dx[adaa_pkg::InW] ? (~dx + 17'd1) : dx;
	assign adx   = adx17[adaa_pkg::InW-1:0];
	assign s     = {x_q[adaa_pkg::InW-1], x_q} + {prev_q[adaa_pkg::InW-1], prev_q};
	assign as17  = s[adaa_pkg::InW] ? (~s + 17'd1) : s;
	assign as15  = as17[adaa_pkg::PW-1:0];
	assign ax    = x_q[adaa_pkg::InW-1] ? (~x_q + 16'd1) : x_q;
	assign p17   = {x_q[adaa_pkg::InW-1], x_q} + 17'(adaa_pkg::HalfRange);

	assign idx_n  = idx_q + adaa_pkg::IdxW'(1);
	assign wgt    = adaa_pkg::PW'(adaa_pkg::FullRange) - r_q;
	assign prod_a = ra_q * wgt;
	assign prod_b = rb_q * r_q;
	assign mprod  = as15 * cs_q;

	assign fdiff = {1'b0, f_q} - {1'b0, fp_q};
	assign afd   = fdiff[adaa_pkg::RomW] ? adaa_pkg::RomW'(~fdiff + 25'd1)
	                                     : fdiff[adaa_pkg::RomW-1:0];

	// A quotient of 4097 or more saturates; otherwise it fits in QW bits.
	assign sat_lim = (adaa_pkg::NumW'(den_q) << (adaa_pkg::QW - 1)) + adaa_pkg::NumW'(den_q);
	assign ge      = num_q >= adaa_pkg::NumW'(den_q);

	assign stat.outside = ax >= adaa_pkg::InW'(adaa_pkg::HalfRange);
	assign stat.mid     = (dx == '0) || (adx < adaa_pkg::InW'(thr));
	assign stat.wide    = as17 >= 17'(adaa_pkg::MidWide);
	assign stat.sat     = num_q >= sat_lim;
	assign stat.more    = k_q != '0;

	assign mag     = sat_q ? adaa_pkg::QW'(adaa_pkg::OneOut) : q_q;
	assign mag_ext = {1'b0, mag};
	assign shaped  = neg_q ? (~mag_ext + adaa_pkg::OutW'(1)) : mag_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			fp_q   <= '0;
		end else if (ctrl.en && ctrl.op == adaa_pkg::OP_DONE) begin
			prev_q <= x_q;
			fp_q   <= f_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			unique case (ctrl.op)
				adaa_pkg::OP_LOAD: begin
					x_q <= sample_in;
				end
				adaa_pkg::OP_FX: begin
					f_q <= adaa_pkg::RomW'({ax, 4'b0}) + adaa_pkg::Rom[adaa_pkg::TableLast]
					       - adaa_pkg::RomW'(adaa_pkg::OutsideBase);
					t_q <= adaa_pkg::TW'(p17[adaa_pkg::PW-1:0])
					       * adaa_pkg::TW'(adaa_pkg::TableLast);
				end
				adaa_pkg::OP_IDX: begin
					idx_q <= adaa_pkg::IdxW'(adaa_pkg::div3(32'(t_q >> adaa_pkg::RndShift)));
				end
				adaa_pkg::OP_ROM: begin
					r_q  <= adaa_pkg::PW'(t_q - adaa_pkg::TW'(idx_q)
					                         * adaa_pkg::TW'(adaa_pkg::FullRange));
					ra_q <= adaa_pkg::Rom[idx_q];
					rb_q <= adaa_pkg::Rom[idx_n];
				end
				adaa_pkg::OP_MUL: begin
					acc_q <= adaa_pkg::AccW'(prod_a);
				end
				adaa_pkg::OP_MAC: begin
					acc_q <= acc_q + adaa_pkg::AccW'(prod_b);
				end
				adaa_pkg::OP_RND: begin
					acc_q <= (acc_q + adaa_pkg::AccW'(adaa_pkg::HalfRange)) >> adaa_pkg::RndShift;
				end
				adaa_pkg::OP_DIV3: begin
					f_q <= adaa_pkg::RomW'(adaa_pkg::div3(acc_q[31:0]));
				end
				adaa_pkg::OP_QUO: begin
					num_q <= adaa_pkg::NumW'({afd, 8'b0}) + adaa_pkg::NumW'(adx >> 1);
					den_q <= adaa_pkg::DenW'(adx);
					neg_q <= fdiff[adaa_pkg::RomW] ^ dx[adaa_pkg::InW];
				end
				adaa_pkg::OP_MSQ: begin
					sq_q  <= as15 * as15;
					sat_q <= stat.wide;
					neg_q <= s[adaa_pkg::InW];
				end
				adaa_pkg::OP_MCS: begin
					cs_q <= adaa_pkg::MidC + 32'(sq_q);
					c9_q <= 33'(adaa_pkg::MidC) + 33'(sq_q) * 33'd9;
				end
				adaa_pkg::OP_MMUL: begin
					num_q <= mprod;
				end
				adaa_pkg::OP_MLD: begin
					num_q <= num_q + adaa_pkg::NumW'(c9_q);
					den_q <= adaa_pkg::DenW'({c9_q, 1'b0});
				end
				adaa_pkg::OP_CHK: begin
					sat_q <= stat.sat;
					den_q <= den_q << (adaa_pkg::QW - 1);
					q_q   <= '0;
					k_q   <= adaa_pkg::KW'(adaa_pkg::QW - 1);
				end
				adaa_pkg::OP_ITER: begin
					if (ge) begin
						num_q <= num_q - adaa_pkg::NumW'(den_q);
					end
					q_q   <= {q_q[adaa_pkg::QW-2:0], ge};
					den_q <= den_q >> 1;
					k_q   <= k_q - adaa_pkg::KW'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/adaa_soft_saturator.sv */
// Soft saturator with first-order antiderivative anti-aliasing.
// One signed Q3.12 sample enters on sample_ch and one shaped Q1.12 sample,
// held within plus or minus one, leaves on shaped_ch for every item. Both
// channels move an item on a clock edge where valid and ready are both high.
// cfg_we writes cfg_data into the small-step threshold; write it only while
// the block is idle.
// A microcoded sequencer steps a shared datapath through the table lookup
// and the interpolation, which a sample of magnitude three or more skips,
// and at most one 13-step restoring division per item. sample_ch is ready
// only in the sequencer's idle step, which follows right after a result is
// loaded, so the block takes no new item before its last result is loaded.
// The result sits in an output register, so the next item is accepted and
// worked on while the receiver stalls; the sequencer waits in its last step
// only if a second result is ready before the first has been taken.
// Reset clears the previous sample and its antiderivative to zero, sets the
// threshold to 4 and empties the output register. The antiderivative table
// is a constant and needs no fill after reset.
module adaa_soft_saturator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [adaa_pkg::ThrW-1:0]     cfg_data,
	adaa_in_if.sink                       sample_ch,
	adaa_out_if.source                    shaped_ch
);

	adaa_pkg::dp_ctrl_t              ctrl;
	adaa_pkg::dp_stat_t              stat;
	logic [adaa_pkg::ThrW-1:0]       thr_q;
	logic                            out_valid_q;
	logic [adaa_pkg::OutW-1:0]       out_data_q;
	logic [adaa_pkg::OutW-1:0]       shaped;
	logic                            out_busy;
	logic                            out_load;

	// The output register is busy while it holds a result nobody has taken.
	assign out_busy = out_valid_q && !shaped_ch.ready;
	assign out_load = ctrl.en && (ctrl.op == adaa_pkg::OP_DONE);

	assign sample_ch.ready      = ctrl.op == adaa_pkg::OP_LOAD;
	assign shaped_ch.valid      = out_valid_q;
	assign shaped_ch.sample_out = out_data_q;

	adaa_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.in_valid (sample_ch.valid),
		.out_busy (out_busy),
		.ctrl     (ctrl)
	);

	adaa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sample_in (sample_ch.sample_in),
		.thr       (thr_q),
		.stat      (stat),
		.shaped    (shaped)
	);

	// Small-step threshold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= adaa_pkg::ThrReset;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// Output register: loaded in the sequencer's final step, which never
	// runs while an earlier result is still waiting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (shaped_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= shaped;
		end
	end

endmodule
